>>> hdl/ydr_pkg.sv
// Package for the YUV difference to RGB pixel core.
// Holds the configuration types, register indexes and color conversion constants.
// No dependencies; used by every module in hdl/.
package ydr_pkg;

  // Field widths that the interface fixes.
  localparam int SAMPLE_W = 16;
  localparam int DEPTH_W  = 5;
  localparam int GAIN_W   = 8;
  localparam int PIX_W    = 8;
  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_A       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_B       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_AMPLIFICATION = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MARK_MODE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MONOCHROME    = 3'd4;

  // Reset values of the registers.
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd1;

  // The smallest sample depth; also the output depth.
  localparam logic [DEPTH_W-1:0] DEPTH_MIN = 5'd8;

  // Chroma is centered on this code at 8 bits.
  localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

  // Fixed-point YUV to RGB coefficients, scaled by 256.
  localparam logic signed [10:0] COEF_RV = 11'sd359;
  localparam logic signed [10:0] COEF_GU = 11'sd88;
  localparam logic signed [10:0] COEF_GV = 11'sd183;
  localparam logic signed [10:0] COEF_BU = 11'sd454;

  localparam logic signed [11:0] PIX_MAX = 12'sd255;

  // Number of register stages from input to output.
  localparam int PIPE_DEPTH = 5;

  // Settings derived from the configuration registers, shared by all stages.
  typedef struct packed {
    logic [DEPTH_W-1:0] da;    // effective depth of frame A
    logic [DEPTH_W-1:0] db;    // effective depth of frame B
    logic [DEPTH_W-1:0] ua;    // left shift that aligns frame A
    logic [DEPTH_W-1:0] ub;    // left shift that aligns frame B
    logic [DEPTH_W-1:0] sh;    // right shift from the common depth to 8 bits
    logic [GAIN_W-1:0]  gain;
    logic               mark;
    logic               mono;
  } cfg_t;

  // Clip a conversion sum to the 8-bit pixel range.
  function automatic logic [PIX_W-1:0] clip8(input logic signed [11:0] v);
    logic [PIX_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > PIX_MAX) begin
      r = PIX_MAX[PIX_W-1:0];
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/ydr_diff.sv
// First pipeline stage: aligns both frames' samples to the common depth and subtracts.
// Depends on ydr_pkg.
module ydr_diff #(
  parameter int W = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ydr_pkg::cfg_t                      cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ydr_pkg::SAMPLE_W-1:0]       luma_a,
  input  logic [ydr_pkg::SAMPLE_W-1:0]       luma_b,
  input  logic [ydr_pkg::SAMPLE_W-1:0]       cb_a,
  input  logic [ydr_pkg::SAMPLE_W-1:0]       cb_b,
  input  logic [ydr_pkg::SAMPLE_W-1:0]       cr_a,
  input  logic [ydr_pkg::SAMPLE_W-1:0]       cr_b,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [W:0]                  dy,
  output logic signed [W:0]                  du,
  output logic signed [W:0]                  dv,
  output logic                               differs
);

  logic [W-1:0] mask_a, mask_b;
  logic [W-1:0] ya, yb, ua_s, ub_s, va, vb;
  logic signed [W:0] dy_c, du_c, dv_c;

  // A depth equal to W shifts every bit out, leaving a full mask.
  assign mask_a = ~({W{1'b1}} << cfg.da);
  assign mask_b = ~({W{1'b1}} << cfg.db);

  assign ya   = (luma_a[W-1:0] & mask_a) << cfg.ua;
  assign yb   = (luma_b[W-1:0] & mask_b) << cfg.ub;
  assign ua_s = (cb_a[W-1:0] & mask_a) << cfg.ua;
  assign ub_s = (cb_b[W-1:0] & mask_b) << cfg.ub;
  assign va   = (cr_a[W-1:0] & mask_a) << cfg.ua;
  assign vb   = (cr_b[W-1:0] & mask_b) << cfg.ub;

  assign dy_c = $signed({1'b0, ya}) - $signed({1'b0, yb});
  assign du_c = cfg.mono ? '0 : $signed({1'b0, ua_s}) - $signed({1'b0, ub_s});
  assign dv_c = cfg.mono ? '0 : $signed({1'b0, va}) - $signed({1'b0, vb});

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dy      <= dy_c;
      du      <= du_c;
      dv      <= dv_c;
      differs <= (dy_c != 0) || (du_c != 0) || (dv_c != 0);
    end
  end

endmodule

>>> hdl/ydr_gain.sv
// Second and third pipeline stages: gain on the differences, then offset, clip and
// reduction to 8 bits. Depends on ydr_pkg.
module ydr_gain #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ydr_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [W:0]     dy,
  input  logic signed [W:0]     du,
  input  logic signed [W:0]     dv,
  input  logic                  differs,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            y8,
  output logic signed [8:0]     u8,
  output logic signed [8:0]     v8,
  output logic                  out_differs
);

  localparam int PW = W + 10;
  localparam logic [PW-1:0] MID_BASE  = PW'(128);
  localparam logic [PW-1:0] SPAN_BASE = PW'(256);

  logic                 a_valid, a_ready, a_differs;
  logic signed [PW-1:0] py, pu, pv;
  logic signed [8:0]    k;
  logic [PW-1:0]        mid, maxv;
  logic [7:0]           y_c, u_c, v_c;

  // Mark mode leaves the differences unscaled.
  assign k    = cfg.mark ? 9'sd1 : $signed({1'b0, cfg.gain});
  assign mid  = MID_BASE << cfg.sh;
  assign maxv = (SPAN_BASE << cfg.sh) - PW'(1);

  function automatic logic [7:0] to8(input logic signed [PW-1:0] p,
                                     input logic [PW-1:0] m,
                                     input logic [PW-1:0] mx,
                                     input logic [ydr_pkg::DEPTH_W-1:0] s);
    logic signed [PW-1:0] t;
    logic [PW-1:0]        c;
    t = p + $signed(m);
    if (t < 0) begin
      c = '0;
    end else if ($unsigned(t) > mx) begin
      c = mx;
    end else begin
      c = $unsigned(t);
    end
    c = c >> s;
    return c[7:0];
  endfunction

  assign a_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      py        <= dy * k;
      pu        <= du * k;
      pv        <= dv * k;
      a_differs <= differs;
    end
  end

  assign y_c = to8(py, mid, maxv, cfg.sh);
  assign u_c = to8(pu, mid, maxv, cfg.sh);
  assign v_c = to8(pv, mid, maxv, cfg.sh);

  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      y8          <= y_c;
      u8          <= $signed({1'b0, u_c}) - ydr_pkg::CHROMA_OFFSET;
      v8          <= $signed({1'b0, v_c}) - ydr_pkg::CHROMA_OFFSET;
      out_differs <= a_differs;
    end
  end

endmodule

>>> hdl/ydr_csc.sv
// Fourth and fifth pipeline stages: fixed YUV to RGB conversion with clipping and the
// red marker. Depends on ydr_pkg.
module ydr_csc (
  input  logic                           clk,
  input  logic                           rst,
  input  ydr_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     y8,
  input  logic signed [8:0]              u8,
  input  logic signed [8:0]              v8,
  input  logic                           differs,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ydr_pkg::PIX_W-1:0]      red,
  output logic [ydr_pkg::PIX_W-1:0]      green,
  output logic [ydr_pkg::PIX_W-1:0]      blue
);

  logic                c_valid, c_ready, c_paint;
  logic [7:0]          c_y;
  logic signed [19:0]  p_rv, p_gu, p_gv, p_bu;
  logic signed [11:0]  ys, sum_r, sum_g, sum_b;

  assign c_ready  = !out_valid || out_ready;
  assign in_ready = !c_valid || c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        c_valid <= in_valid;
      end
      if (c_ready) begin
        out_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_rv    <= v8 * ydr_pkg::COEF_RV;
      p_gu    <= u8 * ydr_pkg::COEF_GU;
      p_gv    <= v8 * ydr_pkg::COEF_GV;
      p_bu    <= u8 * ydr_pkg::COEF_BU;
      c_y     <= y8;
      c_paint <= cfg.mark && differs;
    end
  end

  // Taking the upper product bits is a floor division by 256.
  assign ys    = $signed({4'b0000, c_y});
  assign sum_r = ys + p_rv[19:8];
  assign sum_g = ys - p_gu[19:8] - p_gv[19:8];
  assign sum_b = ys + p_bu[19:8];

  always_ff @(posedge clk) begin
    if (c_ready && c_valid) begin
      if (c_paint) begin
        red   <= ydr_pkg::PIX_MAX[ydr_pkg::PIX_W-1:0];
        green <= '0;
        blue  <= '0;
      end else begin
        red   <= ydr_pkg::clip8(sum_r);
        green <= ydr_pkg::clip8(sum_g);
        blue  <= ydr_pkg::clip8(sum_b);
      end
    end
  end

endmodule

>>> hdl/yuv_difference_to_rgb_pixel_core.sv
// Top level of the YUV frame difference to RGB display pixel core.
// Holds the configuration registers and chains ydr_diff, ydr_gain and ydr_csc.
// Depends on ydr_pkg.

// The core turns one co-sited pair of YUV samples from two frames into one 8-bit RGB
// pixel that shows how the frames differ. It takes one pixel transfer per clock and
// delivers one result transfer per clock when the output side is ready; each pixel
// passes through the core by way of its five register stages, one after another (align and
// subtract, gain, offset and clip, color products, sum and clip). Every stage holds
// its own valid bit and loads whenever it is empty or its successor takes its data,
// so bubbles close up and a stall at the output backs up stage by stage without
// losing or repeating a pixel; the input stays ready as long as any stage has room.
// Samples of each frame are masked to that frame's depth and shifted up to the larger
// of the two depths before subtraction. In mark mode any nonzero difference gives pure
// red, otherwise the differences are scaled by the amplification, offset to mid-gray,
// clipped and reduced to 8 bits, then converted with fixed integer coefficients. In
// monochrome mode only luma is compared. Depths below 8 act as 8 and depths above
// MAX_SAMPLE_BITS act as MAX_SAMPLE_BITS. Configuration is written through cfg_we,
// cfg_index and cfg_data, one register per clock, and should only change while no
// pixel is inside the core; writes to indexes past the last register are ignored.
module yuv_difference_to_rgb_pixel_core #(
  parameter int MAX_SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ydr_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [ydr_pkg::REG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ydr_pkg::SAMPLE_W-1:0]        luma_a,
  input  logic [ydr_pkg::SAMPLE_W-1:0]        luma_b,
  input  logic [ydr_pkg::SAMPLE_W-1:0]        cb_a,
  input  logic [ydr_pkg::SAMPLE_W-1:0]        cb_b,
  input  logic [ydr_pkg::SAMPLE_W-1:0]        cr_a,
  input  logic [ydr_pkg::SAMPLE_W-1:0]        cr_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ydr_pkg::PIX_W-1:0]           red,
  output logic [ydr_pkg::PIX_W-1:0]           green,
  output logic [ydr_pkg::PIX_W-1:0]           blue
);

  localparam int W = MAX_SAMPLE_BITS;
  localparam logic [ydr_pkg::DEPTH_W-1:0] DEPTH_MAX = ydr_pkg::DEPTH_W'(MAX_SAMPLE_BITS);

  // Configuration registers.
  logic [ydr_pkg::DEPTH_W-1:0] depth_a, depth_b;
  logic [ydr_pkg::GAIN_W-1:0]  amplification;
  logic                        mark_mode, monochrome;

  logic [ydr_pkg::DEPTH_W-1:0] da_e, db_e, dout;
  ydr_pkg::cfg_t               cfg;

  // Links between the pipeline segments.
  logic                 d_valid, d_ready, d_differs;
  logic signed [W:0]    d_y, d_u, d_v;
  logic                 g_valid, g_ready, g_differs;
  logic [7:0]           g_y;
  logic signed [8:0]    g_u, g_v;

  // Pixels inside the core, tracked for the checks below.
  logic [2:0]           occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_a       <= ydr_pkg::DEPTH_RESET;
      depth_b       <= ydr_pkg::DEPTH_RESET;
      amplification <= ydr_pkg::GAIN_RESET;
      mark_mode     <= 1'b0;
      monochrome    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ydr_pkg::REG_DEPTH_A:       depth_a       <= cfg_data[ydr_pkg::DEPTH_W-1:0];
        ydr_pkg::REG_DEPTH_B:       depth_b       <= cfg_data[ydr_pkg::DEPTH_W-1:0];
        ydr_pkg::REG_AMPLIFICATION: amplification <= cfg_data;
        ydr_pkg::REG_MARK_MODE:     mark_mode     <= cfg_data[0];
        ydr_pkg::REG_MONOCHROME:    monochrome    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Effective depths and the shifts that follow from them, plain logic. The user must keep
  // the configuration static while pixels are in flight; the core does not enforce this.
  assign da_e = (depth_a < ydr_pkg::DEPTH_MIN) ? ydr_pkg::DEPTH_MIN :
                (depth_a > DEPTH_MAX) ? DEPTH_MAX : depth_a;
  assign db_e = (depth_b < ydr_pkg::DEPTH_MIN) ? ydr_pkg::DEPTH_MIN :
                (depth_b > DEPTH_MAX) ? DEPTH_MAX : depth_b;
  assign dout = (da_e > db_e) ? da_e : db_e;

  always_comb begin
    cfg.da   = da_e;
    cfg.db   = db_e;
    cfg.ua   = dout - da_e;
    cfg.ub   = dout - db_e;
    cfg.sh   = dout - ydr_pkg::DEPTH_MIN;
    cfg.gain = amplification;
    cfg.mark = mark_mode;
    cfg.mono = monochrome;
  end

  ydr_diff #(.W(W)) u_diff (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .luma_a    (luma_a),
    .luma_b    (luma_b),
    .cb_a      (cb_a),
    .cb_b      (cb_b),
    .cr_a      (cr_a),
    .cr_b      (cr_b),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .dy        (d_y),
    .du        (d_u),
    .dv        (d_v),
    .differs   (d_differs)
  );

  ydr_gain #(.W(W)) u_gain (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (d_valid),
    .in_ready    (d_ready),
    .dy          (d_y),
    .du          (d_u),
    .dv          (d_v),
    .differs     (d_differs),
    .out_valid   (g_valid),
    .out_ready   (g_ready),
    .y8          (g_y),
    .u8          (g_u),
    .v8          (g_v),
    .out_differs (g_differs)
  );

  ydr_csc u_csc (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .y8        (g_y),
    .u8        (g_u),
    .v8        (g_v),
    .differs   (g_differs),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  // A ready output side must never hold back the input.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the output side was ready");

  // The core never holds more pixels than it has stages.
  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= 3'(ydr_pkg::PIPE_DEPTH))
    else $error("more pixels in flight than pipeline stages");

  // A result can only be offered for a pixel that went in.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy != 3'd0)
    else $error("result offered with no pixel in flight");

  // A full pipeline refuses input until the output side takes a result.
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (occupancy == 3'(ydr_pkg::PIPE_DEPTH)) && !out_ready |-> !in_ready)
    else $error("input accepted into a full pipeline");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

>>> tb/sv/tb_yuv_difference_to_rgb_pixel_core.sv
// Self-checking testbench for yuv_difference_to_rgb_pixel_core.
// It predicts each RGB difference pixel from the pixel and register values, then checks it.
// Depends on ydr_pkg and the core RTL in hdl/.
`timescale 1ns / 1ps

module tb_yuv_difference_to_rgb_pixel_core;

  localparam int MAX_BITS = 16;
  localparam int HALF_PERIOD = 10;
  // Idle cycles after the last result before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 2 * ydr_pkg::PIPE_DEPTH;
  // The one long receiver hold-off, in cycles. It is long enough to fill every stage.
  localparam int LONG_HOLD = 150;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 55;

  // These are the color conversion weights, scaled by 256.
  localparam int WEIGHT_RV = 359;
  localparam int WEIGHT_GU = 88;
  localparam int WEIGHT_GV = 183;
  localparam int WEIGHT_BU = 454;

  typedef struct packed {
    logic [ydr_pkg::SAMPLE_W-1:0] luma_a;
    logic [ydr_pkg::SAMPLE_W-1:0] luma_b;
    logic [ydr_pkg::SAMPLE_W-1:0] cb_a;
    logic [ydr_pkg::SAMPLE_W-1:0] cb_b;
    logic [ydr_pkg::SAMPLE_W-1:0] cr_a;
    logic [ydr_pkg::SAMPLE_W-1:0] cr_b;
  } sample_set_t;

  typedef struct packed {
    logic [ydr_pkg::PIX_W-1:0] red;
    logic [ydr_pkg::PIX_W-1:0] green;
    logic [ydr_pkg::PIX_W-1:0] blue;
  } rgb_pixel_t;

  // Every input of the core has a known value from time zero.
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [ydr_pkg::REG_IDX_W-1:0]  cfg_index = '0;
  logic [ydr_pkg::REG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [ydr_pkg::SAMPLE_W-1:0]   luma_a = '0;
  logic [ydr_pkg::SAMPLE_W-1:0]   luma_b = '0;
  logic [ydr_pkg::SAMPLE_W-1:0]   cb_a = '0;
  logic [ydr_pkg::SAMPLE_W-1:0]   cb_b = '0;
  logic [ydr_pkg::SAMPLE_W-1:0]   cr_a = '0;
  logic [ydr_pkg::SAMPLE_W-1:0]   cr_b = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [ydr_pkg::PIX_W-1:0]      red;
  logic [ydr_pkg::PIX_W-1:0]      green;
  logic [ydr_pkg::PIX_W-1:0]      blue;

  // These are the register values as the core should hold them. They change only while
  // the core is empty.
  logic [ydr_pkg::DEPTH_W-1:0] cur_depth_a = ydr_pkg::DEPTH_RESET;
  logic [ydr_pkg::DEPTH_W-1:0] cur_depth_b = ydr_pkg::DEPTH_RESET;
  logic [ydr_pkg::GAIN_W-1:0]  cur_gain = ydr_pkg::GAIN_RESET;
  logic                        cur_mark = 1'b0;
  logic                        cur_mono = 1'b0;

  // Each accepted pixel adds one predicted result here, oldest first.
  rgb_pixel_t predicted_pixels[$];
  rgb_pixel_t oldest_pixel;
  int         mismatches = 0;

  // The test sequence asks for a long hold-off by raising hold_requests. The receiver
  // process counts the hold-off itself.
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int style_left = 0;
  int rx_style = 0;

  yuv_difference_to_rgb_pixel_core #(.MAX_SAMPLE_BITS(MAX_BITS)) DUT (.*);

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------

  // A depth register outside 8..MAX_BITS acts as the nearest legal depth.
  function automatic int eff_bits(logic [ydr_pkg::DEPTH_W-1:0] d);
    if (d < 8) begin
      return 8;
    end
    if (d > MAX_BITS) begin
      return MAX_BITS;
    end
    return d;
  endfunction

  // Keep the low bits of a sample up to its frame depth, then shift it to the common depth.
  function automatic int aligned(logic [ydr_pkg::SAMPLE_W-1:0] s, int bits, int up);
    int v;
    v = s;
    v = v & ((1 << bits) - 1);
    return v << up;
  endfunction

  function automatic int clamp(int v, int hi);
    if (v < 0) begin
      return 0;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // This computes the display pixel for one pair of co-sited samples with the current
  // registers. The >>> on a signed int is a floor shift, which the conversion needs for
  // negative chroma.
  function automatic rgb_pixel_t difference_pixel(sample_set_t p);
    int da, db, dout, sh, mid, top, gain;
    int dy, du, dv, y8, u8, v8;
    rgb_pixel_t px;
    da = eff_bits(cur_depth_a);
    db = eff_bits(cur_depth_b);
    dout = (da > db) ? da : db;
    sh = dout - 8;
    mid = 128 << sh;
    top = (1 << dout) - 1;
    gain = cur_gain;
    dy = aligned(p.luma_a, da, dout - da) - aligned(p.luma_b, db, dout - db);
    du = 0;
    dv = 0;
    if (!cur_mono) begin
      du = aligned(p.cb_a, da, dout - da) - aligned(p.cb_b, db, dout - db);
      dv = aligned(p.cr_a, da, dout - da) - aligned(p.cr_b, db, dout - db);
    end
    if (cur_mark && (dy != 0 || du != 0 || dv != 0)) begin
      px.red = 8'd255;
      px.green = 8'd0;
      px.blue = 8'd0;
    end else begin
      // In mark mode with no difference, the pixel goes through unscaled, so it is
      // mid-gray.
      if (!cur_mark) begin
        dy = dy * gain;
        du = du * gain;
        dv = dv * gain;
      end
      y8 = clamp(dy + mid, top) >> sh;
      u8 = (clamp(du + mid, top) >> sh) - 128;
      v8 = (clamp(dv + mid, top) >> sh) - 128;
      px.red = 8'(clamp(y8 + ((v8 * WEIGHT_RV) >>> 8), 255));
      px.green = 8'(clamp(y8 - ((u8 * WEIGHT_GU) >>> 8) - ((v8 * WEIGHT_GV) >>> 8), 255));
      px.blue = 8'(clamp(y8 + ((u8 * WEIGHT_BU) >>> 8), 255));
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // A result transfer takes place at a rising edge where out_valid and out_ready are both
  // high. The outputs are read in the active region of that edge, so the values are the
  // ones from before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (predicted_pixels.size() == 0) begin
        report_mismatch($sformatf("result (%0d,%0d,%0d) with no pixel outstanding",
                                  red, green, blue));
      end else begin
        oldest_pixel = predicted_pixels.pop_front();
        if (red !== oldest_pixel.red) begin
          report_mismatch($sformatf("red is %0d, predicted %0d", red, oldest_pixel.red));
        end
        if (green !== oldest_pixel.green) begin
          report_mismatch($sformatf("green is %0d, predicted %0d", green,
                                    oldest_pixel.green));
        end
        if (blue !== oldest_pixel.blue) begin
          report_mismatch($sformatf("blue is %0d, predicted %0d", blue, oldest_pixel.blue));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Receiver: it switches among several stall patterns and runs each for a random
  // stretch. One pattern never stalls. A requested hold-off overrides the pattern.
  // ---------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = holds_served + 1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style = $urandom_range(0, 3);
        style_left = $urandom_range(8, 80);
      end
      style_left = style_left - 1;
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // Sender and register port
  // ---------------------------------------------------------------------------------

  // This is called just after a falling edge. It offers one pixel and holds it until the
  // transfer, then returns at the next falling edge with in_valid still high. The caller
  // lowers in_valid when a gap follows.
  task automatic send_pixel(input sample_set_t p);
    in_valid <= 1'b1;
    luma_a <= p.luma_a;
    luma_b <= p.luma_b;
    cb_a <= p.cb_a;
    cb_b <= p.cb_b;
    cr_a <= p.cr_a;
    cr_b <= p.cr_b;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predicted_pixels.push_back(difference_pixel(p));
    @(negedge clk);
  endtask

  task automatic send_samples(input logic [15:0] la, lb, ca, cb, ra, rb);
    sample_set_t p;
    p = '{la, lb, ca, cb, ra, rb};
    send_pixel(p);
  endtask

  // This stops offering pixels and waits until every predicted result has arrived.
  // A few more cycles then pass, so any extra result would show up.
  task automatic stop_and_drain();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (predicted_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // This drives one register write for the next rising edge. cfg_we stays high for
  // back-to-back writes.
  task automatic write_register(input logic [ydr_pkg::REG_IDX_W-1:0] idx,
                                input logic [ydr_pkg::REG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      ydr_pkg::REG_DEPTH_A:       cur_depth_a = data[ydr_pkg::DEPTH_W-1:0];
      ydr_pkg::REG_DEPTH_B:       cur_depth_b = data[ydr_pkg::DEPTH_W-1:0];
      ydr_pkg::REG_AMPLIFICATION: cur_gain = data[ydr_pkg::GAIN_W-1:0];
      ydr_pkg::REG_MARK_MODE:     cur_mark = data[0];
      ydr_pkg::REG_MONOCHROME:    cur_mono = data[0];
      default: ;
    endcase
  endtask

  // This changes the settings only once the core is empty. Data bits above the width of a
  // register are random, because the register keeps only its own bits. A write to an
  // index past the last register comes first each time, and it must leave all settings
  // alone.
  task automatic set_config(input int da, db, gain, mark, mono);
    logic [ydr_pkg::REG_DATA_W-1:0] data;
    stop_and_drain();
    write_register(ydr_pkg::REG_IDX_W'($urandom_range(ydr_pkg::REG_MONOCHROME + 1,
                                                       (1 << ydr_pkg::REG_IDX_W) - 1)),
                   ydr_pkg::REG_DATA_W'($urandom));
    data = ydr_pkg::REG_DATA_W'($urandom);
    data[ydr_pkg::DEPTH_W-1:0] = ydr_pkg::DEPTH_W'(da);
    write_register(ydr_pkg::REG_DEPTH_A, data);
    data = ydr_pkg::REG_DATA_W'($urandom);
    data[ydr_pkg::DEPTH_W-1:0] = ydr_pkg::DEPTH_W'(db);
    write_register(ydr_pkg::REG_DEPTH_B, data);
    write_register(ydr_pkg::REG_AMPLIFICATION, ydr_pkg::REG_DATA_W'(gain));
    data = ydr_pkg::REG_DATA_W'($urandom);
    data[0] = mark[0];
    write_register(ydr_pkg::REG_MARK_MODE, data);
    data = ydr_pkg::REG_DATA_W'($urandom);
    data[0] = mono[0];
    write_register(ydr_pkg::REG_MONOCHROME, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One pair of samples for one plane. Most pairs are equal or nearly equal once they are
  // aligned, so mark mode and gain see small differences, not only saturation. The other
  // pairs are independent, full 16-bit, or at the extremes. Some samples also carry junk
  // above their frame depth.
  task automatic make_channel(output logic [15:0] a, output logic [15:0] b);
    int da, db, dout, drop, c, t, mask_a, mask_b;
    da = eff_bits(cur_depth_a);
    db = eff_bits(cur_depth_b);
    dout = (da > db) ? da : db;
    drop = dout - ((da < db) ? da : db);
    mask_a = (1 << da) - 1;
    mask_b = (1 << db) - 1;
    c = $urandom_range(0, (1 << dout) - 1);
    c = (c >> drop) << drop;
    a = 16'(c >> (dout - da));
    b = 16'(c >> (dout - db));
    case ($urandom_range(0, 9))
      3, 4, 5: begin
        t = b;
        t = t + int'($urandom_range(0, 6)) - 3;
        b = 16'(t & mask_b);
      end
      6, 7: begin
        a = 16'($urandom_range(0, mask_a));
        b = 16'($urandom_range(0, mask_b));
      end
      8: begin
        a = 16'($urandom_range(0, 65535));
        b = 16'($urandom_range(0, 65535));
      end
      9: begin
        if ($urandom_range(0, 1) == 1) begin
          a = 16'(mask_a);
          b = 16'd0;
        end else begin
          a = 16'd0;
          b = 16'(mask_b);
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      a = a | (16'($urandom) & ~16'(mask_a));
    end
    if ($urandom_range(0, 7) == 0) begin
      b = b | (16'($urandom) & ~16'(mask_b));
    end
  endtask

  task automatic make_pixel(output sample_set_t p);
    make_channel(p.luma_a, p.luma_b);
    make_channel(p.cb_a, p.cb_b);
    make_channel(p.cr_a, p.cr_b);
  endtask

  // This sends random pixels in bursts of random length. Random gaps fall between
  // bursts, and some gaps are zero, which makes long runs with no idling.
  task automatic run_random_items(input int count);
    int left, burst, gap;
    sample_set_t p;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        make_pixel(p);
        send_pixel(p);
        burst--;
        left--;
      end
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  function automatic int random_depth();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 31);
    end
    return $urandom_range(8, 16);
  endfunction

  function automatic int random_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // ---------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------

  // These pixels use the reset settings: 8-bit frames and a gain of one. They cover zero
  // difference, both full-scale signs, a difference of one, and samples wider than their
  // depth that match once masked.
  task automatic test_reset_values();
    send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_samples(16'h00FF, 16'h0000, 16'h00FF, 16'h0000, 16'h00FF, 16'h0000);
    send_samples(16'h0000, 16'h00FF, 16'h0000, 16'h00FF, 16'h0000, 16'h00FF);
    send_samples(16'hFFFF, 16'h00FF, 16'hAB12, 16'h0012, 16'h5500, 16'h0000);
    send_samples(16'h0080, 16'h007F, 16'h0040, 16'h0041, 16'h00C0, 16'h00BF);
  endtask

  // These pixels use full 16-bit frames, then mixed 8- and 16-bit frames at maximum gain.
  task automatic test_deep_samples();
    set_config(16, 16, 1, 0, 0);
    send_samples(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    send_samples(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_samples(16'h8000, 16'h7FFF, 16'h1234, 16'h1234, 16'hEDCB, 16'hEDCC);
    set_config(8, 16, 255, 0, 0);
    send_samples(16'h0001, 16'h0100, 16'h00FF, 16'hFF00, 16'h0080, 16'h8000);
    send_samples(16'h0080, 16'h8001, 16'h0080, 16'h7FFF, 16'h0081, 16'h8000);
    send_samples(16'hA5C3, 16'h5A3C, 16'h0F0F, 16'hF0F0, 16'h3355, 16'hCCAA);
  endtask

  // With zero gain, every difference vanishes and every pixel is mid-gray.
  task automatic test_zero_gain();
    set_config(12, 10, 0, 0, 0);
    send_samples(16'h0FFF, 16'h0000, 16'h0000, 16'h03FF, 16'h0FFF, 16'h0000);
    send_samples(16'h0123, 16'h0321, 16'h0800, 16'h0100, 16'h0001, 16'h03FE);
  endtask

  // In mark mode, any difference gives red and an exact match gives mid-gray, whatever
  // the gain. In monochrome mode, a chroma-only difference does not count.
  task automatic test_mark_mode();
    set_config(10, 10, 7, 1, 0);
    send_samples(16'h03FF, 16'h03FF, 16'h0155, 16'h0155, 16'h02AA, 16'h02AA);
    send_samples(16'h0200, 16'h0201, 16'h0155, 16'h0155, 16'h02AA, 16'h02AA);
    send_samples(16'h0200, 16'h0200, 16'h0000, 16'h0001, 16'h02AA, 16'h02AA);
    send_samples(16'h0200, 16'h0200, 16'h0155, 16'h0155, 16'h03FF, 16'h0000);
    set_config(10, 10, 7, 1, 1);
    send_samples(16'h0100, 16'h0100, 16'h03FF, 16'h0000, 16'h0000, 16'h03FF);
    send_samples(16'h0100, 16'h00FF, 16'h03FF, 16'h03FF, 16'h0000, 16'h0000);
  endtask

  // In monochrome mode without marking, only the luma difference reaches the output.
  task automatic test_monochrome();
    set_config(9, 14, 2, 0, 1);
    send_samples(16'h01FF, 16'h2000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_samples(16'h0001, 16'h3FFF, 16'h1234, 16'h4321, 16'h8888, 16'h7777);
  endtask

  // A depth below 8 acts as 8, and a depth above MAX_BITS acts as MAX_BITS.
  task automatic test_depth_clamp();
    set_config(0, 31, 1, 0, 0);
    send_samples(16'hFF80, 16'h8000, 16'h00FF, 16'h0000, 16'h1200, 16'h1234);
    send_samples(16'h0000, 16'hFFFF, 16'h0180, 16'h7F00, 16'h0000, 16'h0000);
    set_config(3, 17, 4, 0, 0);
    send_samples(16'h0081, 16'h8000, 16'h007F, 16'h8000, 16'hFF40, 16'h4000);
  endtask

  // The receiver holds off while the sender offers pixels back to back, so the core fills
  // and lowers in_ready. The sender then pauses until every result is out, and it sends
  // again into a receiver that may still be slow.
  task automatic test_output_backpressure();
    sample_set_t p;
    set_config(16, 12, 3, 0, 0);
    hold_requests = hold_requests + 1;
    repeat (60) begin
      make_pixel(p);
      send_pixel(p);
    end
    stop_and_drain();
    run_random_items(20);
  endtask

  // Each phase takes random settings. Out-of-range depths are included, and most phases
  // have mark mode and monochrome off.
  task automatic test_random_settings();
    repeat (RANDOM_PHASES) begin
      set_config(random_depth(), random_depth(), random_gain(),
                 ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0));
      run_random_items(ITEMS_PER_PHASE);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_deep_samples();
    test_zero_gain();
    test_mark_mode();
    test_monochrome();
    test_depth_clamp();
    test_output_backpressure();
    test_random_settings();
    stop_and_drain();
    if (mismatches == 0) begin
      $display("tb_yuv_difference_to_rgb_pixel_core: PASS");
    end else begin
      $display("tb_yuv_difference_to_rgb_pixel_core: FAIL");
    end
    $finish;
  end

  // This is far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("ERROR: timeout with %0d results outstanding", predicted_pixels.size());
    $display("tb_yuv_difference_to_rgb_pixel_core: FAIL");
    $finish;
  end

endmodule
